FILE: hw/rtl/tpbd_pkg.sv
// ----------------------------------------------------------------------------
// tpbd_pkg
// Shared widths, register indexes, reset values and types for the touch pad
// baseline detector.
// ----------------------------------------------------------------------------
package tpbd_pkg;

  localparam int NUM_PADS_DEFAULT = 5;

  localparam int SAMPLE_W   = 16;
  localparam int FILT_W     = 8;
  localparam int BASE_W     = 24;
  localparam int COEF_W     = 9;
  localparam int THRESH_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IIR_COEF        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd1;

  localparam logic [COEF_W-1:0]   COEF_ONE     = 9'd256;
  localparam logic [COEF_W-1:0]   COEF_RESET   = 9'd26;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd10;

  localparam int PAD_MASK_W  = 5;
  localparam int BTN_MASK_W  = 8;
  localparam int FIRST_W     = 4;
  localparam int OUT_TDATA_W = 24;

  localparam logic [FIRST_W-1:0] FIRST_NONE = 4'hF;

  // Filter settings seen by every lane
  typedef struct packed {
    logic [COEF_W-1:0]   coef;
    logic [THRESH_W-1:0] thresh;
  } cfg_t;

  // Per-beat lane control
  typedef struct packed {
    logic load;    // scan beat accepted this cycle
    logic primed;  // history and baselines already seeded
  } lane_ctrl_t;

endpackage

FILE: hw/rtl/tpbd_lane.sv
// ----------------------------------------------------------------------------
// tpbd_lane
// One pad: peak-of-two filter, press compare and baseline IIR update.
// ----------------------------------------------------------------------------
module tpbd_lane (
  input  logic                           clk,
  input  tpbd_pkg::lane_ctrl_t           ctrl,
  input  tpbd_pkg::cfg_t                 cfg,
  input  logic [tpbd_pkg::SAMPLE_W-1:0]  sample,
  output logic                           pressed
);

  logic [tpbd_pkg::SAMPLE_W-1:0] prev;
  logic [tpbd_pkg::BASE_W-1:0]   baseline;
  logic [tpbd_pkg::BASE_W-1:0]   baseline_next;

  logic [tpbd_pkg::SAMPLE_W-1:0] peak;
  logic [tpbd_pkg::FILT_W-1:0]   filt;
  logic [tpbd_pkg::FILT_W:0]     limit;
  logic signed [24:0]            diff;
  logic signed [34:0]            prod;
  logic signed [34:0]            acc;

  assign peak  = (sample > prev) ? sample : prev;
  assign filt  = peak[tpbd_pkg::FILT_W-1:0];
  assign limit = {1'b0, filt} + {1'b0, cfg.thresh};

  // press when (filt + thresh) * 256 < baseline, compared at full width
  assign pressed = ctrl.primed && ({7'b0, limit, 8'b0} < baseline);

  // b*256 + c*(f*256 - b) is the same sum as c*f*256 + (256-c)*b, one multiply
  assign diff = $signed({9'b0, filt, 8'b0}) - $signed({1'b0, baseline});
  assign prod = $signed({1'b0, cfg.coef}) * diff;
  assign acc  = $signed({3'b0, baseline, 8'b0}) + prod;

  always_comb begin
    if (!ctrl.primed) begin
      baseline_next = {sample, 8'b0};
    end else if (!pressed) begin
      baseline_next = acc[31:8];
    end else begin
      baseline_next = baseline;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prev     <= sample;
      baseline <= baseline_next;
    end
  end

endmodule

FILE: hw/rtl/tpbd_merge.sv
// ----------------------------------------------------------------------------
// tpbd_merge
// Combines lane press flags into pad mask, button mask and first button,
// and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module tpbd_merge #(
  parameter int NUM_PADS = tpbd_pkg::NUM_PADS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [NUM_PADS-1:0]                pressed,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tpbd_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int BtnN = 2 * (NUM_PADS - 1);

  logic                              shift;
  logic [BtnN-1:0]                   btn;
  logic [BtnN+tpbd_pkg::BTN_MASK_W-1:0]     btn_ext;
  logic [NUM_PADS+tpbd_pkg::PAD_MASK_W-1:0] pad_ext;
  logic [tpbd_pkg::FIRST_W-1:0]      first;
  logic [tpbd_pkg::OUT_TDATA_W-1:0]  data_next;

  assign shift = pressed[NUM_PADS-1];

  always_comb begin
    for (int i = 0; i < BtnN; i++) begin
      btn[i] = pressed[i/2] && (((i % 2) == 1) ? shift : !shift);
    end
  end

  // lowest set button; index is cut to the field width
  always_comb begin
    first = tpbd_pkg::FIRST_NONE;
    for (int i = BtnN - 1; i >= 0; i--) begin
      if (btn[i]) first = 4'(i);
    end
  end

  assign btn_ext = {{tpbd_pkg::BTN_MASK_W{1'b0}}, btn};
  assign pad_ext = {{tpbd_pkg::PAD_MASK_W{1'b0}}, pressed};

  assign data_next = {7'b0, first, btn_ext[tpbd_pkg::BTN_MASK_W-1:0],
                      pad_ext[tpbd_pkg::PAD_MASK_W-1:0]};

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= data_next;
  end

endmodule

FILE: hw/rtl/touch_pad_baseline_detector_top.sv
// ----------------------------------------------------------------------------
// touch_pad_baseline_detector_top
// Capacitive touch pad press detector with per-pad baseline tracking.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata: pad0_sample[15:0] .. pad(N-1)_sample, 16 bits each
//  m_*     | out | tdata: pad_pressed_mask[4:0], button_pressed_mask[12:5],
//          |     |        first_button[16:13] (signed, 0xF = none), zero pad
//  cfg_*   | in  | index 0 iir_coef (9b, >256 saturates), 1 press_threshold
//
// One scan beat per cycle while s_tready is high; a result beat is presented
// from the output register in the cycle after its scan is accepted. Per-pad
// work is one lane per pad, each with a single 10x25 multiply for the IIR
// step in the accept cycle. s_tready drops only while a result beat waits
// and m_tready is low. Synchronous reset sets the config registers to their
// reset values and clears the output valid and the primed flag; the first
// scan afterwards seeds history and baselines and reports no press.
// ----------------------------------------------------------------------------
module touch_pad_baseline_detector_top #(
  parameter int NUM_PADS = tpbd_pkg::NUM_PADS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // scan beats: pad samples, pad 0 in the low bits
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [NUM_PADS*tpbd_pkg::SAMPLE_W-1:0] s_tdata,
  // result beats: pad_pressed_mask, button_pressed_mask, first_button
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tpbd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // register writes
  input  logic                                cfg_we,
  input  logic [tpbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tpbd_pkg::cfg_t       cfg;
  tpbd_pkg::lane_ctrl_t ctrl;
  logic                 primed;
  logic                 accept;
  logic [NUM_PADS-1:0]  pressed;

  assign accept      = s_tvalid && s_tready;
  assign ctrl.load   = accept;
  assign ctrl.primed = primed;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef   <= tpbd_pkg::COEF_RESET;
      cfg.thresh <= tpbd_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpbd_pkg::REG_IIR_COEF: begin
          cfg.coef <= (cfg_data > tpbd_pkg::COEF_ONE) ? tpbd_pkg::COEF_ONE : cfg_data;
        end
        tpbd_pkg::REG_PRESS_THRESHOLD: begin
          cfg.thresh <= cfg_data[tpbd_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // first accepted scan only seeds the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (accept) begin
      primed <= 1'b1;
    end
  end

  for (genvar g = 0; g < NUM_PADS; g++) begin : g_lane
    tpbd_lane u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .cfg     (cfg),
      .sample  (s_tdata[g*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W]),
      .pressed (pressed[g])
    );
  end

  tpbd_merge #(
    .NUM_PADS (NUM_PADS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .pressed   (pressed),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: hw/rtl/tpbd_checker.sv
// ----------------------------------------------------------------------------
// tpbd_checker
// Port-level checks on the touch pad baseline detector, bound to the top.
// ----------------------------------------------------------------------------
module tpbd_checker #(
  parameter int NUM_PADS = tpbd_pkg::NUM_PADS_DEFAULT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [tpbd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  logic [4:0] pad;
  logic [7:0] btn;
  logic [3:0] first;

  assign pad   = m_tdata[4:0];
  assign btn   = m_tdata[12:5];
  assign first = m_tdata[16:13];

  // a waiting result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // output register empties or drains: input side must be open
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("scan beat blocked with free output register");

  // accepted scan shows up as a result beat next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("result beat missing after accepted scan");

  // with five pads, pads 0 to 3 each show in their two buttons; no button means no first
  a_btn_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (NUM_PADS == 5) |->
      ((btn[0] | btn[1]) == pad[0]) && ((btn[2] | btn[3]) == pad[1]) &&
      ((btn[4] | btn[5]) == pad[2]) && ((btn[6] | btn[7]) == pad[3]) &&
      ((btn == 8'd0) == (first == tpbd_pkg::FIRST_NONE)))
    else $error("button mask disagrees with pad mask");

endmodule

bind touch_pad_baseline_detector_top tpbd_checker #(
  .NUM_PADS (NUM_PADS)
) u_tpbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/touch_pad_baseline_detector_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_pad_baseline_detector_top_test
// Self-checking bench for the touch pad baseline detector. A scoreboard model
// tracks history, baselines and press state per pad and predicts each result
// beat. Directed scans cover seeding, sample extremes and the button map.
// Random touch sequences then run under several filter settings, with random
// stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module touch_pad_baseline_detector_top_test;

  localparam int PADS = tpbd_pkg::NUM_PADS_DEFAULT;

  // result beat layout, low bit up
  localparam int PAD_LSB   = 0;
  localparam int BTN_LSB   = PAD_LSB + tpbd_pkg::PAD_MASK_W;
  localparam int FIRST_LSB = BTN_LSB + tpbd_pkg::BTN_MASK_W;
  localparam int USED_W    = FIRST_LSB + tpbd_pkg::FIRST_W;

  // register indexes with no register behind them
  localparam logic [tpbd_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [tpbd_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam int DRAIN_LIMIT  = 2000;  // cycles to wait for late beats
  localparam int SETTLE_TIME  = 4;     // block output is registered
  localparam int OUT_HOLD_LEN = 60;    // long receiver hold-off

  typedef logic [PADS*tpbd_pkg::SAMPLE_W-1:0] scan_t;

  typedef struct {
    logic [tpbd_pkg::PAD_MASK_W-1:0] pad_mask;
    logic [tpbd_pkg::BTN_MASK_W-1:0] btn_mask;
    logic [tpbd_pkg::FIRST_W-1:0]    first_btn;
  } touch_result_t;

  // DUT signals, all inputs known from time zero
  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [PADS*tpbd_pkg::SAMPLE_W-1:0]  s_tdata = '0;   // pad0_sample .. pad4_sample
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [tpbd_pkg::OUT_TDATA_W-1:0]    m_tdata;  // pad mask, button mask, first, zeros
  logic                                cfg_we = 1'b0;
  logic [tpbd_pkg::CFG_IDX_W-1:0]      cfg_index = tpbd_pkg::REG_IIR_COEF;
  logic [tpbd_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // bench control
  bit idle_on = 1'b1;     // random gaps on both sides
  int hold_request = 0;   // receiver hold-off length, picked up by its process
  int error_count = 0;

  touch_result_t pending_results[$];

  // scoreboard model state
  int unsigned                   coef_q8;
  int unsigned                   thresh;
  logic [tpbd_pkg::SAMPLE_W-1:0] hist_sample [PADS];
  logic [tpbd_pkg::BASE_W-1:0]   base_q8     [PADS];
  logic                          pad_down    [PADS];
  logic                          seeded;

  // random touch sequence state
  int pad_level  [PADS];
  int touch_left [PADS];

  touch_pad_baseline_detector_top #(
    .NUM_PADS(PADS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // One scan through the press detector. Updates the model state and returns
  // the result beat the block must produce for it.
  function automatic touch_result_t predict_scan(input scan_t scan);
    touch_result_t                 res;
    logic [tpbd_pkg::SAMPLE_W-1:0] s;
    logic [tpbd_pkg::SAMPLE_W-1:0] peak;
    logic [tpbd_pkg::FILT_W-1:0]   filt;
    longint unsigned               acc;
    logic                          shift;
    int                            first;
    res.pad_mask = '0;
    res.btn_mask = '0;
    first = -1;
    if (!seeded) begin
      // seeding scan: full 16-bit sample goes straight into the baseline
      for (int p = 0; p < PADS; p++) begin
        s = scan[p*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W];
        hist_sample[p] = s;
        base_q8[p] = {s, 8'h00};
        pad_down[p] = 1'b0;
      end
      seeded = 1'b1;
    end else begin
      for (int p = 0; p < PADS; p++) begin
        s = scan[p*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W];
        peak = (s > hist_sample[p]) ? s : hist_sample[p];
        filt = peak[tpbd_pkg::FILT_W-1:0];          // only the low byte survives
        hist_sample[p] = s;
        pad_down[p] = ((longint'(filt) + longint'(thresh)) << 8) < longint'(base_q8[p]);
        if (!pad_down[p]) begin
          // baseline tracks only while released
          acc = longint'(coef_q8) * (longint'(filt) << 8)
              + longint'(int'(tpbd_pkg::COEF_ONE) - int'(coef_q8)) * longint'(base_q8[p]);
          base_q8[p] = acc[tpbd_pkg::BASE_W+7:8];
        end
      end
    end
    shift = pad_down[PADS-1];
    for (int p = 0; p < PADS; p++)
      res.pad_mask[p] = pad_down[p];
    for (int b = 0; b < 2*(PADS-1); b++) begin
      if (pad_down[b/2] && ((b % 2 == 1) ? shift : !shift)) begin
        res.btn_mask[b] = 1'b1;
        if (first < 0)
          first = b;
      end
    end
    res.first_btn = first[tpbd_pkg::FIRST_W-1:0];   // -1 gives all ones
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
    error_count++;
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_reg(input logic [tpbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpbd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == tpbd_pkg::REG_IIR_COEF)
      coef_q8 = (value > tpbd_pkg::COEF_ONE) ? int'(tpbd_pkg::COEF_ONE) : int'(value);
    else if (idx == tpbd_pkg::REG_PRESS_THRESHOLD)
      thresh = int'(value[tpbd_pkg::THRESH_W-1:0]);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one scan beat and wait for it to be taken. An optional idle gap of
  // random length goes in front of it.
  task automatic send_scan(input scan_t scan);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = scan;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_scan(scan));
  endtask

  // Stop offering, let every expected beat arrive, then a few spare cycles.
  task automatic drain_results();
    int waited;
    @(negedge clk);
    s_tvalid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  // Pads in touched read low (50), the rest sit at 200.
  function automatic scan_t press_scan(input logic [PADS-1:0] touched);
    scan_t scan;
    for (int p = 0; p < PADS; p++)
      scan[p*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W] = touched[p] ? 16'd50 : 16'd200;
    return scan;
  endfunction

  // Random scan: mostly touch sequences around each pad's level, with some
  // junk in the high byte and some fully random readings mixed in.
  function automatic scan_t next_scan();
    scan_t scan;
    int    v;
    for (int p = 0; p < PADS; p++) begin
      if (touch_left[p] == 0 && $urandom_range(0, 7) == 0)
        touch_left[p] = $urandom_range(2, 6);
      if (touch_left[p] > 0) begin
        v = pad_level[p] - int'($urandom_range(20, 120));
        touch_left[p]--;
      end else begin
        v = pad_level[p] + int'($urandom_range(0, 6)) - 3;
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      scan[p*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W] = v[tpbd_pkg::SAMPLE_W-1:0];
      case ($urandom_range(0, 15))
        0: scan[p*tpbd_pkg::SAMPLE_W +: tpbd_pkg::SAMPLE_W] = 16'($urandom_range(0, 65535));
        1: scan[p*tpbd_pkg::SAMPLE_W+tpbd_pkg::FILT_W +:
                tpbd_pkg::SAMPLE_W-tpbd_pkg::FILT_W] = 8'($urandom_range(0, 255));
        default: ;
      endcase
    end
    return scan;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // First scan after reset seeds everything and reports no press. Pad 3 is
  // seeded above the byte range to show the full 16 bits reach the baseline;
  // it recovers once its low byte reads high enough.
  task automatic test_seed_scan();
    send_scan({16'h0064, 16'h0100, 16'h00C8, 16'h00FF, 16'h0000});
    drain_results();
  endtask

  // Sample extremes and patterns that make the max and the low-byte cut matter.
  task automatic test_sample_extremes();
    send_scan({PADS{16'hFFFF}});
    send_scan({PADS{16'h0000}});
    send_scan({PADS{16'hFF00}});
    send_scan({PADS{16'h00FF}});
    send_scan({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    drain_results();
  endtask

  // Walk the button map: pads alone and in groups, with and without the shift pad.
  task automatic test_button_map();
    // calibrate: a full threshold releases every pad, a coefficient of one
    // snaps all baselines to 200
    write_reg(tpbd_pkg::REG_IIR_COEF, tpbd_pkg::COEF_ONE);
    write_reg(tpbd_pkg::REG_PRESS_THRESHOLD, 9'd255);
    send_scan(press_scan(5'b00000));
    send_scan(press_scan(5'b00000));
    drain_results();
    write_reg(tpbd_pkg::REG_PRESS_THRESHOLD, 9'(tpbd_pkg::THRESH_RESET));
    // a press shows on the second low scan because of the max with history
    send_scan(press_scan(5'b00001));
    send_scan(press_scan(5'b00001));
    send_scan(press_scan(5'b00110));
    send_scan(press_scan(5'b00110));
    send_scan(press_scan(5'b11000));
    send_scan(press_scan(5'b11000));
    send_scan(press_scan(5'b10101));
    send_scan(press_scan(5'b10101));
    send_scan(press_scan(5'b11111));
    send_scan(press_scan(5'b11111));
    send_scan(press_scan(5'b00000));
    drain_results();
  endtask

  // Receiver holds off for a long stretch while scans keep coming, so the
  // output register fills and the input stalls.
  task automatic test_output_hold();
    write_reg(tpbd_pkg::REG_IIR_COEF, tpbd_pkg::COEF_RESET);
    hold_request = OUT_HOLD_LEN;
    repeat (12) send_scan(next_scan());
    drain_results();
  endtask

  task automatic run_phase(input logic [tpbd_pkg::CFG_DATA_W-1:0] coef,
                           input logic [tpbd_pkg::CFG_DATA_W-1:0] thr,
                           input int count);
    write_reg(tpbd_pkg::REG_IIR_COEF, coef);
    write_reg(tpbd_pkg::REG_PRESS_THRESHOLD, thr);
    for (int p = 0; p < PADS; p++) begin
      pad_level[p] = $urandom_range(40, 250);
      touch_left[p] = 0;
    end
    repeat (count) send_scan(next_scan());
    drain_results();
  endtask

  // Random touch traffic across filter settings, extremes included. Writes to
  // unused indexes must leave both registers alone.
  task automatic test_register_sweep();
    run_phase(tpbd_pkg::COEF_RESET, 9'(tpbd_pkg::THRESH_RESET), 150);
    run_phase(9'd0, 9'd0, 120);                 // frozen baselines
    write_reg(REG_UNUSED_2, 9'($urandom_range(0, 511)));
    write_reg(REG_UNUSED_3, 9'h1FF);
    run_phase(tpbd_pkg::COEF_ONE, 9'd255, 120);
    run_phase(9'h1FF, 9'd0, 120);               // saturates to one
    run_phase(9'd257, 9'd128, 120);
    run_phase(9'd1, 9'd5, 120);
    run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 255)), 120);
  endtask

  // Last stretch runs back to back with no gaps on either side.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_phase(9'd64, 9'd20, 250);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts plus the requested hold-off
  // --------------------------------------------------------------------------
  initial begin : result_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(0, 4);   // start a stall burst
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    touch_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none expected", 32'd0, 32'(m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[PAD_LSB +: tpbd_pkg::PAD_MASK_W] !== want.pad_mask)
          report_mismatch("pad_pressed_mask", 32'(want.pad_mask),
                          32'(m_tdata[PAD_LSB +: tpbd_pkg::PAD_MASK_W]));
        if (m_tdata[BTN_LSB +: tpbd_pkg::BTN_MASK_W] !== want.btn_mask)
          report_mismatch("button_pressed_mask", 32'(want.btn_mask),
                          32'(m_tdata[BTN_LSB +: tpbd_pkg::BTN_MASK_W]));
        if (m_tdata[FIRST_LSB +: tpbd_pkg::FIRST_W] !== want.first_btn)
          report_mismatch("first_button", 32'(want.first_btn),
                          32'(m_tdata[FIRST_LSB +: tpbd_pkg::FIRST_W]));
        if (m_tdata[tpbd_pkg::OUT_TDATA_W-1:USED_W] !== '0)
          report_mismatch("tdata padding", 32'd0,
                          32'(m_tdata[tpbd_pkg::OUT_TDATA_W-1:USED_W]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    coef_q8 = int'(tpbd_pkg::COEF_RESET);
    thresh = int'(tpbd_pkg::THRESH_RESET);
    seeded = 1'b0;
    for (int p = 0; p < PADS; p++) begin
      hist_sample[p] = '0;
      base_q8[p] = '0;
      pad_down[p] = 1'b0;
      pad_level[p] = 128;
      touch_left[p] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_seed_scan();
    test_sample_extremes();
    test_button_map();
    test_output_hold();
    test_register_sweep();
    test_steady_stream();

    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("result beats never delivered", 32'(pending_results.size()), 32'd0);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : run_limit
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tpbd_pkg.sv
hw/rtl/tpbd_lane.sv
hw/rtl/tpbd_merge.sv
hw/rtl/touch_pad_baseline_detector_top.sv
hw/rtl/tpbd_checker.sv
bench/touch_pad_baseline_detector_top_test.sv
